// ===== hdl/wbps_pkg.sv =====
// Package for the wildcard byte pattern scanner: widths, codes, character
// constants, the shared structs and the hex digit decoder.
// Depends on nothing; every other file of the block refers to it by scope.
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 64;
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 64;
    localparam int RLEN_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [RLEN_W-1:0]   t_rlen;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_len LEN_MAX = t_len'(MAX_PATTERN_BYTES);

    // Transaction kinds on the input channel. The fourth code is ignored.
    localparam t_kind KIND_CHAR  = 2'd0;
    localparam t_kind KIND_BEGIN = 2'd1;
    localparam t_kind KIND_BYTE  = 2'd2;

    // Result status codes.
    localparam t_status STATUS_FOUND    = 2'd0;
    localparam t_status STATUS_NONE     = 2'd1;
    localparam t_status STATUS_OVERFLOW = 2'd2;

    // Pattern text characters.
    localparam t_char CH_QUESTION = 8'h3F;
    localparam t_char CH_DIGIT_0  = 8'h30;
    localparam t_char CH_DIGIT_9  = 8'h39;
    localparam t_char CH_UPPER_A  = 8'h41;
    localparam t_char CH_UPPER_F  = 8'h46;
    localparam t_char CH_LOWER_A  = 8'h61;
    localparam t_char CH_LOWER_F  = 8'h66;

    localparam logic [3:0] HEX_TEN = 4'd10;

    // One byte appended to the stored pattern.
    typedef struct packed {
        logic  valid;
        t_char value;
        logic  wild;
    } t_append;

    // A character can append up to two bytes: a flushed lone digit and a wildcard.
    typedef struct packed {
        t_append first;
        t_append second;
    } t_tok_out;

    // Write request for one pattern cell.
    typedef struct packed {
        logic  en;
        t_char value;
        logic  wild;
    } t_cell_wr;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_decode(input t_char c);
        t_char      diff;
        logic [4:0] res;
        res = 5'd0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            diff = c - CH_DIGIT_0;
            res  = {1'b1, diff[3:0]};
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            diff = c - CH_UPPER_A;
            res  = {1'b1, diff[3:0] + HEX_TEN};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            diff = c - CH_LOWER_A;
            res  = {1'b1, diff[3:0] + HEX_TEN};
        end
        return res;
    endfunction

endpackage

// ===== hdl/wbps_in_if.sv =====
// Input channel of the scanner: valid/ready handshake and the item payload.
// Depends on wbps_pkg for the field widths.
interface wbps_in_if;
    logic                  valid;
    logic                  ready;
    wbps_pkg::t_kind       kind;
    wbps_pkg::t_char       pattern_char;
    wbps_pkg::t_addr       base_address;
    wbps_pkg::t_rlen       region_length;
    wbps_pkg::t_addr       result_offset;
    wbps_pkg::t_char       mem_byte;

    modport source (
        output valid, kind, pattern_char, base_address, region_length, result_offset,
               mem_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, pattern_char, base_address, region_length, result_offset,
               mem_byte,
        output ready
    );
endinterface

// ===== hdl/wbps_out_if.sv =====
// Result channel of the scanner: valid/ready handshake, status and address.
// Depends on wbps_pkg for the field widths.
interface wbps_out_if;
    logic              valid;
    logic              ready;
    wbps_pkg::t_status status;
    wbps_pkg::t_addr   match_address;

    modport source (
        output valid, status, match_address,
        input  ready
    );
    modport sink (
        input  valid, status, match_address,
        output ready
    );
endinterface

// ===== hdl/wbps_tokenizer.sv =====
// Pattern text tokenizer: turns characters into appended pattern bytes.
// Depends on wbps_pkg for the character constants, decoder and structs.
module wbps_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_char_en,
    input  logic               i_flush_en,
    input  wbps_pkg::t_char    i_char,
    output wbps_pkg::t_tok_out o_app
);

    logic       r_held_v;
    logic [3:0] r_held;
    logic       r_absorb;
    logic       n_held_v;
    logic [3:0] n_held;
    logic       n_absorb;
    logic [4:0] w_hex;

    always_comb begin
        w_hex    = wbps_pkg::hex_decode(i_char);
        n_held_v = r_held_v;
        n_held   = r_held;
        n_absorb = r_absorb;
        o_app    = '0;
        if (i_flush_en) begin
            // A begin transaction flushes a lone digit and ends any absorption.
            if (r_held_v) begin
                o_app.first.valid = 1'b1;
                o_app.first.value = {4'd0, r_held};
            end
            n_held_v = 1'b0;
            n_held   = 4'd0;
            n_absorb = 1'b0;
        end else if (i_char_en) begin
            n_absorb = 1'b0;
            if (r_absorb && i_char == wbps_pkg::CH_QUESTION) begin
                // Second question mark of a wildcard pair: nothing to do.
            end else if (w_hex[4]) begin
                if (r_held_v) begin
                    o_app.first.valid = 1'b1;
                    o_app.first.value = {r_held, w_hex[3:0]};
                    n_held_v = 1'b0;
                    n_held   = 4'd0;
                end else begin
                    n_held_v = 1'b1;
                    n_held   = w_hex[3:0];
                end
            end else begin
                if (r_held_v) begin
                    o_app.first.valid = 1'b1;
                    o_app.first.value = {4'd0, r_held};
                    n_held_v = 1'b0;
                    n_held   = 4'd0;
                end
                if (i_char == wbps_pkg::CH_QUESTION) begin
                    if (r_held_v) begin
                        o_app.second.valid = 1'b1;
                        o_app.second.wild  = 1'b1;
                    end else begin
                        o_app.first.valid = 1'b1;
                        o_app.first.wild  = 1'b1;
                    end
                    n_absorb = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_held   <= 4'd0;
            r_absorb <= 1'b0;
        end else begin
            r_held_v <= n_held_v;
            r_held   <= n_held;
            r_absorb <= n_absorb;
        end
    end

endmodule

// ===== hdl/wbps_cell.sv =====
// One cell of the match chain: a pattern byte, its wildcard mark and the
// partial match flag handed to the next cell. Depends on wbps_pkg.
module wbps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wbps_pkg::t_cell_wr i_wr,
    input  logic               i_clear,
    input  logic               i_shift,
    input  wbps_pkg::t_char    i_byte,
    input  logic               i_prev_part,
    output logic               o_part,
    output logic               o_hit
);

    wbps_pkg::t_char r_pat;
    logic            r_wild;
    logic            r_part;

    // The pattern prefix up to this cell ends at the incoming byte.
    assign o_hit  = i_prev_part && (r_wild || r_pat == i_byte);
    assign o_part = r_part;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_pat <= i_wr.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wild <= 1'b0;
            r_part <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_wild <= i_wr.wild;
            end
            if (i_clear) begin
                r_part <= 1'b0;
            end else if (i_shift) begin
                r_part <= o_hit;
            end
        end
    end

endmodule

// ===== hdl/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg, wbps_in_if, wbps_out_if, wbps_tokenizer and wbps_cell.
//
// Usage. Transactions arrive on i_in with a kind code. Pattern character
// transactions build the pattern while no scan runs: hex digit pairs are bytes,
// a lone digit before a non-hex character is a byte, and '?' or '??' is a
// wildcard byte. A begin transaction loads the base address, region length and
// result offset and starts a scan; the pattern is kept across scans. Memory byte
// transactions then stream the region in address order, and after the last one
// a single result leaves on o_out with a status and the first match address.
// A begin with a zero region length gives its result at once.
//
// Throughput: one input transaction per cycle, every kind, unless stalled. Each
// byte goes to a row of MAX_PATTERN_BYTES cells; cell j keeps a flag that the
// first j+1 pattern bytes match the stream so far and hands it to cell j+1 on
// the next byte, so the row compares the whole pattern in parallel with no loop.
// Result path: the outcome of the final byte (or the empty-region begin) is
// registered in the capture stage, then the output register adds the result
// offset.
// Reset clears the pattern length, the wildcard marks, the tokenizer, the scan
// and both result stages; pattern bytes themselves are simply overwritten.
// When the receiver stalls, the output register holds its result and one more
// result waits in the capture stage; i_in.ready drops only when both are full.
module wildcard_byte_pattern_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wbps_in_if.sink    i_in,
    wbps_out_if.source o_out
);

    localparam int N = wbps_pkg::MAX_PATTERN_BYTES;

    // Input decode.
    logic w_accept;
    logic w_char_en;
    logic w_begin;
    logic w_byte;

    // Pattern bookkeeping.
    wbps_pkg::t_len     r_len;
    logic               r_ovf;
    wbps_pkg::t_len     w_len1;
    wbps_pkg::t_len     n_len;
    logic               n_ovf;
    logic               w_land0;
    logic               w_land1;
    wbps_pkg::t_tok_out w_app;
    wbps_pkg::t_len     w_last;

    // Cell row.
    wbps_pkg::t_cell_wr w_wr   [N];
    logic               w_part [N];
    logic               w_hit  [N];

    // Scan state.
    logic            r_scanning;
    wbps_pkg::t_rlen r_seen;
    wbps_pkg::t_rlen r_expected;
    wbps_pkg::t_rlen n_seen;
    wbps_pkg::t_addr r_cand;
    wbps_pkg::t_addr n_cand;
    wbps_pkg::t_addr r_extra;
    logic            r_base_nz;
    logic            r_match_seen;
    wbps_pkg::t_addr r_match_base;
    logic            w_full;
    logic            w_hit_now;
    logic            w_finish;

    // Capture stage and output register.
    logic              r_a_valid;
    logic              r_a_ovf;
    logic              r_a_found;
    wbps_pkg::t_addr   r_a_mbase;
    wbps_pkg::t_addr   r_a_extra;
    logic              w_o_free;
    logic              w_a_move;
    logic              r_o_valid;
    wbps_pkg::t_status r_o_status;
    wbps_pkg::t_addr   r_o_addr;
    wbps_pkg::t_addr   w_sum;

    assign w_o_free   = !r_o_valid || o_out.ready;
    assign w_a_move   = r_a_valid && w_o_free;
    assign i_in.ready = !r_a_valid || w_o_free;

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_char_en = w_accept && i_in.kind == wbps_pkg::KIND_CHAR && !r_scanning;
    assign w_begin   = w_accept && i_in.kind == wbps_pkg::KIND_BEGIN;
    assign w_byte    = w_accept && i_in.kind == wbps_pkg::KIND_BYTE && r_scanning;

    wbps_tokenizer u_tokenizer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char_en  (w_char_en),
        .i_flush_en (w_begin),
        .i_char     (i_in.pattern_char),
        .o_app      (w_app)
    );

    // Up to two bytes land per cycle; bytes past capacity only set the flag.
    assign w_land0 = w_app.first.valid && (r_len < wbps_pkg::LEN_MAX);
    assign w_len1  = r_len + wbps_pkg::t_len'(w_land0);
    assign w_land1 = w_app.second.valid && (w_len1 < wbps_pkg::LEN_MAX);
    assign n_len   = w_len1 + wbps_pkg::t_len'(w_land1);
    assign n_ovf   = r_ovf || (w_app.first.valid && !w_land0)
                           || (w_app.second.valid && !w_land1);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic w_sel0;
            logic w_sel1;
            logic w_prev;

            assign w_sel0 = w_land0 && (r_len == wbps_pkg::t_len'(g));
            assign w_sel1 = w_land1 && (w_len1 == wbps_pkg::t_len'(g));
            assign w_wr[g].en    = w_sel0 || w_sel1;
            assign w_wr[g].value = w_sel0 ? w_app.first.value : w_app.second.value;
            assign w_wr[g].wild  = w_sel0 ? w_app.first.wild : w_app.second.wild;

            if (g == 0) begin : g_head
                assign w_prev = 1'b1;
            end else begin : g_body
                assign w_prev = w_part[g-1];
            end

            wbps_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_wr        (w_wr[g]),
                .i_clear     (w_begin),
                .i_shift     (w_byte),
                .i_byte      (i_in.mem_byte),
                .i_prev_part (w_prev),
                .o_part      (w_part[g]),
                .o_hit       (w_hit[g])
            );
        end
    endgenerate

    // The last pattern cell tells whether the whole pattern ends at this byte.
    assign w_last    = r_len - wbps_pkg::t_len'(1);
    assign w_full    = w_hit[w_last[wbps_pkg::IDX_W-1:0]];
    assign w_hit_now = !r_match_seen && !r_ovf && (r_len != '0) && w_full;

    // r_cand tracks base + bytes seen - pattern length, the start address of
    // a match that ends at the current byte.
    assign n_seen   = r_seen + wbps_pkg::t_rlen'(1);
    assign n_cand   = r_cand + wbps_pkg::t_addr'(1);
    assign w_finish = (w_begin && i_in.region_length == '0)
                   || (w_byte && n_seen == r_expected);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_scanning   <= 1'b0;
            r_seen       <= '0;
            r_expected   <= '0;
            r_cand       <= '0;
            r_extra      <= '0;
            r_base_nz    <= 1'b0;
            r_match_seen <= 1'b0;
            r_match_base <= '0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            if (w_begin) begin
                r_scanning   <= i_in.region_length != '0;
                r_seen       <= '0;
                r_expected   <= i_in.region_length;
                r_cand       <= i_in.base_address - wbps_pkg::t_addr'(n_len);
                r_extra      <= i_in.result_offset;
                r_base_nz    <= i_in.base_address != '0;
                r_match_seen <= 1'b0;
            end else if (w_byte) begin
                r_seen <= n_seen;
                r_cand <= n_cand;
                if (w_hit_now) begin
                    r_match_seen <= 1'b1;
                    r_match_base <= n_cand;
                end
                if (w_finish) begin
                    r_scanning <= 1'b0;
                end
            end
        end
    end

    // Capture stage: the scan outcome, before the result offset is added.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_finish) begin
            r_a_valid <= 1'b1;
        end else if (w_a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_a_ovf   <= w_begin ? n_ovf : r_ovf;
            r_a_found <= !w_begin && (r_match_seen || w_hit_now) && r_base_nz;
            r_a_mbase <= w_hit_now ? n_cand : r_match_base;
            r_a_extra <= w_begin ? i_in.result_offset : r_extra;
        end
    end

    // Output register: final status and address.
    assign w_sum = r_a_mbase + r_a_extra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_a_move) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            if (r_a_ovf) begin
                r_o_status <= wbps_pkg::STATUS_OVERFLOW;
                r_o_addr   <= '0;
            end else if (r_a_found && r_a_mbase != '0) begin
                r_o_status <= wbps_pkg::STATUS_FOUND;
                r_o_addr   <= w_sum;
            end else begin
                r_o_status <= wbps_pkg::STATUS_NONE;
                r_o_addr   <= '0;
            end
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.match_address = r_o_addr;

endmodule

// ===== hdl/wbps_checker.sv =====
// Port-level checker for the scanner, attached to the top level by bind.
// Depends on wbps_pkg and on the top level wildcard_byte_pattern_scanner.
module wbps_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input wbps_pkg::t_kind   i_in_kind,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input wbps_pkg::t_status i_out_status,
    input wbps_pkg::t_addr   i_out_addr
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
                                        && $stable(i_out_addr))
        else $error("result changed while stalled");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A fresh result must be caused by an accepted begin or memory byte transaction.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc, 2)
            && ($past(i_in_kind, 2) == wbps_pkg::KIND_BEGIN
                || $past(i_in_kind, 2) == wbps_pkg::KIND_BYTE))
        else $error("result without a finishing transaction");

    // With the result channel empty the input side is never held off.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while no result is pending");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_kind    (i_in.kind),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_addr   (o_out.match_address)
);
